@@ rtl/core/rrts_pkg.sv @@
// Shared constants, types and a helper function of the round-robin task table scheduler.
package rrts_pkg;

	localparam int TASK_SLOTS = 16;
	localparam int CORES      = 4;

	localparam int IDX_W    = $clog2(TASK_SLOTS);
	localparam int CNT_W    = $clog2(TASK_SLOTS + 1);
	localparam int THREAD_W = 16;
	localparam int TASK_W   = 4;
	localparam int CORE_W   = 2;
	localparam int MODE_W   = 2;
	localparam int KILL_W   = 4;

	localparam logic [MODE_W-1:0] MODE_SWITCH = 2'd0;
	localparam logic [MODE_W-1:0] MODE_APPEND = 2'd1;
	localparam logic [MODE_W-1:0] MODE_KILL   = 2'd2;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_DUP      = 3'd1,
		ST_NOTFOUND = 3'd2,
		ST_FULL     = 3'd3,
		ST_SLEEP    = 3'd4,
		ST_ALLHELD  = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RELEASE,
		S_SELECT,
		S_DUP,
		S_APPEND_WR,
		S_FIND,
		S_SHIFT,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [THREAD_W-1:0] thread;
		logic [TASK_W-1:0]   task_id;
		logic                held;
		logic [CORE_W-1:0]   owner;
	} entry_t;

	// Steps an index by one and wraps to zero at the end of the occupied table.
	function automatic logic [IDX_W-1:0] next_idx(logic [IDX_W-1:0] idx, logic [CNT_W-1:0] cnt);
		logic [CNT_W-1:0] inc;
		inc = CNT_W'(idx) + CNT_W'(1);
		if (inc >= cnt) begin
			return '0;
		end
		return idx + IDX_W'(1);
	endfunction

endpackage

@@ rtl/core/rrts_if.sv @@
// Request and response channel interfaces of the round-robin task table scheduler.
interface rrts_req_if;
	logic                             valid;
	logic                             ready;
	logic [rrts_pkg::MODE_W-1:0]      mode;
	logic [rrts_pkg::CORE_W-1:0]      core_id;
	logic                             is_primary;
	logic [rrts_pkg::THREAD_W-1:0]    thread_id;
	logic [rrts_pkg::KILL_W-1:0]      kill_id;

	modport source (output valid, mode, core_id, is_primary, thread_id, kill_id, input ready);
	modport sink (input valid, mode, core_id, is_primary, thread_id, kill_id, output ready);
endinterface

interface rrts_rsp_if;
	logic                             valid;
	logic                             ready;
	rrts_pkg::status_t                status;
	logic [rrts_pkg::TASK_W-1:0]      task_id;
	logic [rrts_pkg::THREAD_W-1:0]    granted_thread;

	modport source (output valid, status, task_id, granted_thread, input ready);
	modport sink (input valid, status, task_id, granted_thread, output ready);
endinterface

@@ rtl/core/rrts_table.sv @@
// Task table memory with one write port and one registered read port.
module rrts_table (
	input  logic                        clk,
	input  logic                        we,
	input  logic [rrts_pkg::IDX_W-1:0]  waddr,
	input  rrts_pkg::entry_t            wdata,
	input  logic                        re,
	input  logic [rrts_pkg::IDX_W-1:0]  raddr,
	output rrts_pkg::entry_t            rdata
);

	rrts_pkg::entry_t mem [rrts_pkg::TASK_SLOTS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/core/round_robin_task_table_scheduler.sv @@
// Top level: sequencer that walks the task table memory for switch, append and kill words.
// Sleep words, unused modes and kills on an empty table go straight to the result state;
// appends on an empty table skip the duplicate scan.
// One word is processed at a time; the next word can be accepted in the cycle after the result
// is parked in the output register.
// Reset clears the task count, the round-robin pointer and the control state; no clearing pass.
module round_robin_task_table_scheduler (
	input  logic       clk,
	input  logic       arst_n,
	rrts_req_if.sink   req,
	rrts_rsp_if.source rsp
);

	localparam int IDX_W = rrts_pkg::IDX_W;
	localparam int CNT_W = rrts_pkg::CNT_W;

	rrts_pkg::state_t state_q, state_nxt;

	logic [rrts_pkg::MODE_W-1:0]   mode_q;
	logic [rrts_pkg::CORE_W-1:0]   core_q;
	logic [rrts_pkg::THREAD_W-1:0] thr_q;
	logic [rrts_pkg::KILL_W-1:0]   kid_q;

	logic [CNT_W-1:0] cnt_q;
	logic [IDX_W-1:0] rr_q;
	logic [IDX_W-1:0] addr_q;
	logic [CNT_W-1:0] iss_q;
	logic [CNT_W-1:0] lim_q;
	logic [CNT_W-1:0] proc_q;
	logic             vld_s1;
	logic [IDX_W-1:0] idx_s1;

	rrts_pkg::status_t             res_status_q;
	logic [rrts_pkg::TASK_W-1:0]   res_task_q;
	logic [rrts_pkg::THREAD_W-1:0] res_thread_q;

	logic                          out_vld_q;
	rrts_pkg::status_t             out_status_q;
	logic [rrts_pkg::TASK_W-1:0]   out_task_q;
	logic [rrts_pkg::THREAD_W-1:0] out_thread_q;

	logic             accept;
	logic             sleep;
	logic             last_s1;
	logic             hit;
	logic             idx_is_last;
	logic             table_full;
	logic             out_load;
	logic             restart;
	logic             rd_en;
	logic             we;
	logic [IDX_W-1:0] waddr;
	rrts_pkg::entry_t wdata;
	rrts_pkg::entry_t rdata;

	assign accept      = req.valid && req.ready;
	assign sleep       = !req.is_primary || (32'(req.core_id) >= rrts_pkg::CORES) ||
	                     (cnt_q == '0);
	assign last_s1     = vld_s1 && (proc_q == lim_q - CNT_W'(1));
	assign idx_is_last = CNT_W'(idx_s1) == cnt_q - CNT_W'(1);
	assign table_full  = 32'(cnt_q) >= rrts_pkg::TASK_SLOTS;
	assign out_load    = (state_q == rrts_pkg::S_DONE) && (!out_vld_q || rsp.ready);
	assign restart     = ((state_q == rrts_pkg::S_IDLE) && accept) ||
	                     ((state_q == rrts_pkg::S_RELEASE) && last_s1) ||
	                     ((state_q == rrts_pkg::S_FIND) && vld_s1 && hit);

	assign req.ready          = state_q == rrts_pkg::S_IDLE;
	assign rsp.valid          = out_vld_q;
	assign rsp.status         = out_status_q;
	assign rsp.task_id        = out_task_q;
	assign rsp.granted_thread = out_thread_q;

	rrts_table u_table (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (rd_en),
		.raddr (addr_q),
		.rdata (rdata)
	);

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			rrts_pkg::S_IDLE: begin
				if (accept) begin
					unique case (req.mode)
						rrts_pkg::MODE_SWITCH: state_nxt = sleep ? rrts_pkg::S_DONE
						                                         : rrts_pkg::S_RELEASE;
						rrts_pkg::MODE_APPEND: state_nxt = (cnt_q == '0) ? rrts_pkg::S_APPEND_WR
						                                                 : rrts_pkg::S_DUP;
						rrts_pkg::MODE_KILL:   state_nxt = (cnt_q == '0) ? rrts_pkg::S_DONE
						                                                 : rrts_pkg::S_FIND;
						default:               state_nxt = rrts_pkg::S_DONE;
					endcase
				end
			end
			rrts_pkg::S_RELEASE: begin
				if (last_s1) begin
					state_nxt = rrts_pkg::S_SELECT;
				end
			end
			rrts_pkg::S_SELECT: begin
				if (vld_s1 && (hit || last_s1)) begin
					state_nxt = rrts_pkg::S_DONE;
				end
			end
			rrts_pkg::S_DUP: begin
				if (vld_s1 && hit) begin
					state_nxt = rrts_pkg::S_DONE;
				end else if (last_s1) begin
					state_nxt = rrts_pkg::S_APPEND_WR;
				end
			end
			rrts_pkg::S_APPEND_WR: state_nxt = rrts_pkg::S_DONE;
			rrts_pkg::S_FIND: begin
				if (vld_s1 && hit) begin
					state_nxt = idx_is_last ? rrts_pkg::S_DONE : rrts_pkg::S_SHIFT;
				end else if (last_s1) begin
					state_nxt = rrts_pkg::S_DONE;
				end
			end
			rrts_pkg::S_SHIFT: begin
				if (last_s1) begin
					state_nxt = rrts_pkg::S_DONE;
				end
			end
			rrts_pkg::S_DONE: begin
				if (out_load) begin
					state_nxt = rrts_pkg::S_IDLE;
				end
			end
			default: state_nxt = rrts_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		rd_en = 1'b0;
		hit   = 1'b0;
		we    = 1'b0;
		waddr = idx_s1;
		wdata = rdata;
		unique case (state_q)
			rrts_pkg::S_RELEASE: begin
				rd_en = iss_q < lim_q;
				hit   = rdata.held && (rdata.owner == core_q);
				if (vld_s1 && hit) begin
					we          = 1'b1;
					wdata.held  = 1'b0;
					wdata.owner = '0;
				end
			end
			rrts_pkg::S_SELECT: begin
				rd_en = iss_q < lim_q;
				hit   = !rdata.held;
				if (vld_s1 && hit) begin
					we          = 1'b1;
					wdata.held  = 1'b1;
					wdata.owner = core_q;
				end
			end
			rrts_pkg::S_DUP: begin
				rd_en = iss_q < lim_q;
				hit   = rdata.thread == thr_q;
			end
			rrts_pkg::S_APPEND_WR: begin
				we            = !table_full;
				waddr         = cnt_q[IDX_W-1:0];
				wdata.thread  = thr_q;
				wdata.task_id = cnt_q[rrts_pkg::TASK_W-1:0];
				wdata.held    = 1'b0;
				wdata.owner   = '0;
			end
			rrts_pkg::S_FIND: begin
				rd_en = iss_q < lim_q;
				hit   = rdata.task_id == kid_q;
			end
			rrts_pkg::S_SHIFT: begin
				rd_en = iss_q < lim_q;
				if (vld_s1) begin
					we    = 1'b1;
					waddr = idx_s1 - IDX_W'(1);
				end
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rrts_pkg::S_IDLE;
			cnt_q   <= '0;
			rr_q    <= '0;
			vld_s1  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			vld_s1  <= rd_en && (state_nxt == state_q);
			if (state_q == rrts_pkg::S_APPEND_WR && !table_full) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if ((state_q == rrts_pkg::S_FIND && vld_s1 && hit && idx_is_last) ||
			    (state_q == rrts_pkg::S_SHIFT && last_s1)) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
			if (state_q == rrts_pkg::S_SELECT && vld_s1 && (hit || last_s1)) begin
				rr_q <= rrts_pkg::next_idx(idx_s1, cnt_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= addr_q;
		if (!restart) begin
			if (rd_en) begin
				iss_q  <= iss_q + CNT_W'(1);
				addr_q <= rrts_pkg::next_idx(addr_q, cnt_q);
			end
			if (vld_s1) begin
				proc_q <= proc_q + CNT_W'(1);
			end
		end
		unique case (state_q)
			rrts_pkg::S_IDLE: begin
				if (accept) begin
					mode_q       <= req.mode;
					core_q       <= req.core_id;
					thr_q        <= req.thread_id;
					kid_q        <= req.kill_id;
					iss_q        <= '0;
					proc_q       <= '0;
					lim_q        <= cnt_q;
					addr_q       <= '0;
					res_task_q   <= '0;
					res_thread_q <= '0;
					unique case (req.mode)
						rrts_pkg::MODE_SWITCH: res_status_q <= rrts_pkg::ST_SLEEP;
						rrts_pkg::MODE_KILL:   res_status_q <= rrts_pkg::ST_NOTFOUND;
						default:               res_status_q <= rrts_pkg::ST_OK;
					endcase
				end
			end
			rrts_pkg::S_RELEASE: begin
				if (last_s1) begin
					iss_q  <= '0;
					proc_q <= '0;
					lim_q  <= cnt_q;
					addr_q <= (CNT_W'(rr_q) >= cnt_q) ? '0 : rr_q;
				end
			end
			rrts_pkg::S_SELECT: begin
				if (vld_s1 && hit) begin
					res_status_q <= rrts_pkg::ST_OK;
					res_task_q   <= rdata.task_id;
					res_thread_q <= rdata.thread;
				end else if (last_s1) begin
					res_status_q <= rrts_pkg::ST_ALLHELD;
				end
			end
			rrts_pkg::S_DUP: begin
				if (vld_s1 && hit) begin
					res_status_q <= rrts_pkg::ST_DUP;
				end
			end
			rrts_pkg::S_APPEND_WR: begin
				if (table_full) begin
					res_status_q <= rrts_pkg::ST_FULL;
				end else begin
					res_status_q <= rrts_pkg::ST_OK;
					res_task_q   <= cnt_q[rrts_pkg::TASK_W-1:0];
				end
			end
			rrts_pkg::S_FIND: begin
				if (vld_s1 && hit) begin
					res_status_q <= rrts_pkg::ST_OK;
					iss_q        <= '0;
					proc_q       <= '0;
					lim_q        <= cnt_q - CNT_W'(1) - CNT_W'(idx_s1);
					addr_q       <= idx_s1 + IDX_W'(1);
				end
			end
			default: begin
				lim_q <= lim_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_load) begin
			out_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_status_q <= res_status_q;
			out_task_q   <= res_task_q;
			out_thread_q <= (mode_q == rrts_pkg::MODE_SWITCH) ? res_thread_q : '0;
		end
	end

endmodule
